// ----- sv/hlrd_pkg.sv -----
// shared types and constants for the record deframer
`timescale 1ns / 1ps

package hlrd_pkg;

    // record layout
    localparam int unsigned KEY_BYTES   = 32;
    localparam int unsigned SPAN_BYTES  = 4;
    localparam int unsigned MAX_RECORDS = 4096;

    // widths of the result fields
    localparam int unsigned NUM_W   = 13;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned REASON_W = 3;

    // result queue sizing
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = 2;
    localparam int unsigned CNT_W      = 3;

    // walk phase
    typedef enum logic [1:0] {
        PH_KEY  = 2'd0,
        PH_SPAN = 2'd1,
        PH_SKIP = 2'd2
    } phase_t;

    // result kinds
    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    // stop reasons
    localparam logic [REASON_W-1:0] STOP_NONE       = 3'd0;
    localparam logic [REASON_W-1:0] STOP_END        = 3'd0;
    localparam logic [REASON_W-1:0] STOP_ZERO_KEY   = 3'd1;
    localparam logic [REASON_W-1:0] STOP_SHORT_SPAN = 3'd2;
    localparam logic [REASON_W-1:0] STOP_OVERRUN    = 3'd3;
    localparam logic [REASON_W-1:0] STOP_TABLE_FULL = 3'd4;

    // one result item
    typedef struct packed {
        logic                kind;
        logic [NUM_W-1:0]    number;
        logic [ADDR_W-1:0]   start;
        logic [ADDR_W-1:0]   payload;
        logic [REASON_W-1:0] reason;
        logic                last;
    } result_t;

    // results produced by one byte, handed to the queue
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

// ----- sv/hlrd_step.sv -----
// walk state and per-byte record checks
`timescale 1ns / 1ps

module hlrd_step (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_fire,
    input  logic [7:0]             data_byte,
    input  logic                   cfg_fire,
    input  logic [31:0]            cfg_data,
    output hlrd_pkg::push_t        push
);
    import hlrd_pkg::*;

    localparam logic [5:0]  KEY_LAST    = 6'(KEY_BYTES);
    localparam logic [33:0] KEY_SUM     = 34'(KEY_BYTES);
    localparam logic [34:0] SLOT_SUM    = 35'(KEY_BYTES + SPAN_BYTES);
    localparam logic [34:0] NEXT_SLOT   = 35'(2 * KEY_BYTES + SPAN_BYTES);
    localparam logic [1:0]  SPAN_LAST   = 2'(SPAN_BYTES - 1);
    localparam logic [31:0] SPAN_MIN    = 32'(SPAN_BYTES);
    localparam logic [NUM_W-1:0] MAX_REC = NUM_W'(MAX_RECORDS);

    phase_t      phase_reg, phase_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] pos_reg, pos_next;
    logic [5:0]  fc_reg, fc_next;
    logic        kaz_reg, kaz_next;
    logic [31:0] span_reg, span_next;
    logic [31:0] start_reg, start_next;
    logic [33:0] nstart_reg, nstart_next;
    logic [31:0] skip_reg, skip_next;
    logic [NUM_W-1:0] found_reg, found_next;
    logic        done_reg, done_next;

    // working values
    logic [34:0] len35;
    logic [31:0] start_eff;
    logic        kaz_new;
    logic [5:0]  fc_inc;
    logic [31:0] span_new;
    logic [33:0] rec_end;
    logic [34:0] slot_end;
    logic [34:0] skip_slot_end;
    logic [31:0] skip_dec;
    logic [31:0] plen;
    logic [NUM_W-1:0] found_inc;
    logic [1:0]  n_res;
    result_t     res0, res1;

    function automatic result_t make_result(
        input logic                kind,
        input logic [NUM_W-1:0]    number,
        input logic [ADDR_W-1:0]   start,
        input logic [ADDR_W-1:0]   payload,
        input logic [REASON_W-1:0] reason
    );
        result_t r;
        r.kind    = kind;
        r.number  = number;
        r.start   = start;
        r.payload = payload;
        r.reason  = reason;
        r.last    = 1'b0;
        return r;
    endfunction

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_KEY;
            length_reg <= '0;
            pos_reg    <= '0;
            fc_reg     <= '0;
            kaz_reg    <= 1'b1;
            span_reg   <= '0;
            start_reg  <= '0;
            nstart_reg <= '0;
            skip_reg   <= '0;
            found_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            pos_reg    <= pos_next;
            fc_reg     <= fc_next;
            kaz_reg    <= kaz_next;
            span_reg   <= span_next;
            start_reg  <= start_next;
            nstart_reg <= nstart_next;
            skip_reg   <= skip_next;
            found_reg  <= found_next;
            done_reg   <= done_next;
        end
    end

    // shared sums and compares
    always_comb
    begin
        len35     = {3'b000, length_reg};
        start_eff = (fc_reg == 6'd0) ? pos_reg : start_reg;
        kaz_new   = ((fc_reg == 6'd0) ? 1'b1 : kaz_reg) & (data_byte == 8'd0);
        fc_inc    = fc_reg + 6'd1;
        span_new  = span_reg | ({24'b0, data_byte} << {fc_reg[1:0], 3'b000});
        rec_end   = {2'b00, start_reg} + KEY_SUM + {2'b00, span_new};
        slot_end  = {3'b000, start_reg} + NEXT_SLOT + {3'b000, span_new};
        skip_slot_end = {1'b0, nstart_reg} + SLOT_SUM;
        skip_dec  = (skip_reg != 32'd0) ? (skip_reg - 32'd1) : skip_reg;
        plen      = span_new - SPAN_MIN;
        found_inc = found_reg + NUM_W'(1);
    end

    // next state and results for one byte
    always_comb
    begin
        phase_next  = phase_reg;
        length_next = cfg_fire ? cfg_data : length_reg;
        pos_next    = pos_reg;
        fc_next     = fc_reg;
        kaz_next    = kaz_reg;
        span_next   = span_reg;
        start_next  = start_reg;
        nstart_next = nstart_reg;
        skip_next   = skip_reg;
        found_next  = found_reg;
        done_next   = done_reg;
        n_res       = 2'd0;
        res0        = '0;
        res1        = '0;

        if (in_fire && !done_reg)
        begin
            pos_next = pos_reg + 32'd1;
            case (phase_reg)
                PH_KEY:
                begin
                    if (fc_reg == 6'd0 && pos_reg == 32'd0 &&
                        (SLOT_SUM > len35 || found_reg >= MAX_REC))
                    begin
                        // first slot cannot hold a record
                        done_next = 1'b1;
                        n_res     = 2'd1;
                        res0      = make_result(KIND_FINISH, found_reg, 32'd0, 32'd0,
                                        (SLOT_SUM > len35) ? STOP_END : STOP_TABLE_FULL);
                    end
                    else
                    begin
                        start_next = start_eff;
                        kaz_next   = kaz_new;
                        fc_next    = fc_inc;
                        if (fc_inc >= KEY_LAST)
                        begin
                            if (kaz_new)
                            begin
                                done_next = 1'b1;
                                n_res     = 2'd1;
                                res0      = make_result(KIND_FINISH, found_reg, start_eff,
                                                32'd0, STOP_ZERO_KEY);
                            end
                            else
                            begin
                                phase_next = PH_SPAN;
                                fc_next    = 6'd0;
                                span_next  = 32'd0;
                            end
                        end
                    end
                end
                PH_SPAN:
                begin
                    span_next = span_new;
                    fc_next   = fc_inc;
                    if (fc_reg[1:0] == SPAN_LAST)
                    begin
                        fc_next     = 6'd0;
                        nstart_next = rec_end;
                        if (span_new < SPAN_MIN)
                        begin
                            done_next = 1'b1;
                            n_res     = 2'd1;
                            res0      = make_result(KIND_FINISH, found_reg, start_reg,
                                            32'd0, STOP_SHORT_SPAN);
                        end
                        else if ({1'b0, rec_end} > len35)
                        begin
                            done_next = 1'b1;
                            n_res     = 2'd1;
                            res0      = make_result(KIND_FINISH, found_reg, start_reg,
                                            32'd0, STOP_OVERRUN);
                        end
                        else
                        begin
                            n_res      = 2'd1;
                            res0       = make_result(KIND_RECORD, found_reg, start_reg,
                                             plen, STOP_NONE);
                            found_next = found_inc;
                            skip_next  = plen;
                            if (plen == 32'd0)
                            begin
                                // empty payload: next slot checked at once
                                phase_next = PH_KEY;
                                start_next = rec_end[31:0];
                                if (slot_end > len35 || found_inc >= MAX_REC)
                                begin
                                    done_next = 1'b1;
                                    n_res     = 2'd2;
                                    res1      = make_result(KIND_FINISH, found_inc,
                                                    rec_end[31:0], 32'd0,
                                                    (slot_end > len35) ? STOP_END
                                                                       : STOP_TABLE_FULL);
                                end
                            end
                            else
                            begin
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 32'd0)
                    begin
                        phase_next = PH_KEY;
                        fc_next    = 6'd0;
                        start_next = nstart_reg[31:0];
                        if (skip_slot_end > len35 || found_reg >= MAX_REC)
                        begin
                            done_next = 1'b1;
                            n_res     = 2'd1;
                            res0      = make_result(KIND_FINISH, found_reg,
                                            nstart_reg[31:0], 32'd0,
                                            (skip_slot_end > len35) ? STOP_END
                                                                    : STOP_TABLE_FULL);
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_KEY;
                end
            endcase
        end

        // mark the final result of this byte
        if (n_res == 2'd1)
        begin
            res0.last = 1'b1;
        end
        else if (n_res == 2'd2)
        begin
            res1.last = 1'b1;
        end

        push.count = n_res;
        push.r0    = res0;
        push.r1    = res1;
    end

endmodule

// ----- sv/hlrd_result_fifo.sv -----
// small result queue taking up to two results per cycle
`timescale 1ns / 1ps

module hlrd_result_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  hlrd_pkg::push_t   push,
    output logic              space_ok,
    output logic              out_valid,
    input  logic              out_ready,
    output hlrd_pkg::result_t out_data
);
    import hlrd_pkg::*;

    localparam logic [CNT_W-1:0] SPACE_LIMIT = CNT_W'(FIFO_DEPTH - 2);

    result_t          mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pop;
    logic [PTR_W-1:0] wr_plus1;

    // pointer and count update
    always_comb
    begin
        pop      = out_valid & out_ready;
        wr_plus1 = wr_reg + PTR_W'(1);
        wr_next  = wr_reg + PTR_W'(push.count);
        rd_next  = pop ? (rd_reg + PTR_W'(1)) : rd_reg;
        cnt_next = cnt_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_reg] <= push.r0;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_plus1] <= push.r1;
        end
    end

    // read side
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rd_reg];
    assign space_ok  = (cnt_reg <= SPACE_LIMIT);

endmodule

// ----- sv/hash_length_record_deframer.sv -----
// top level of the key / span record deframer
`timescale 1ns / 1ps
// results: a byte's results are registered into the result queue and offered in order from its head
// throughput: one byte per cycle while in_ready is high; the walk state updates in a single pass per byte
// a byte ending a record may give two results, queued in a four-entry result queue
// in_ready drops only while fewer than two queue entries are free
// reset: asynchronous, active low; walk restarts at offset 0, stream_length clears to 0

module hash_length_record_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] stream_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [12:0] record_number,
    output logic [31:0] record_start,
    output logic [31:0] payload_bytes,
    output logic [2:0]  stop_reason,
    output logic        last_result
);
    import hlrd_pkg::*;

    push_t   push;
    result_t head;
    logic    space_ok;
    logic    in_fire;
    logic    cfg_fire;

    // handshakes
    assign in_ready  = space_ok;
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid & in_ready;
    assign cfg_fire  = cfg_valid & cfg_ready;

    // per-byte walk
    hlrd_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .data_byte (data_byte),
        .cfg_fire  (cfg_fire),
        .cfg_data  (stream_length),
        .push      (push)
    );

    // result queue
    hlrd_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (head)
    );

    // result beat fields
    assign result_kind   = head.kind;
    assign record_number = head.number;
    assign record_start  = head.start;
    assign payload_bytes = head.payload;
    assign stop_reason   = head.reason;
    assign last_result   = head.last;

endmodule

// ----- bench/tb_top.sv -----
// testbench for the key / span record deframer: random record streams checked beat by beat
`timescale 1ns / 1ps

module tb_top;
    import hlrd_pkg::*;

    // how the record walk is brought to its end in this run
    typedef enum {
        END_FIRST_SLOT,
        END_OF_DATA,
        END_ZERO_KEY,
        END_SHORT_SPAN,
        END_OVERRUN,
        END_OPEN_RECORD
    } walk_end_t;

    // shapes of record key
    typedef enum {
        KEY_RANDOM,
        KEY_ONE_HOT,
        KEY_ONES,
        KEY_ZERO
    } key_style_t;

    // walk predictor and store of the result beats still due
    class deframe_board_t;
        logic [31:0] stream_len = '0;
        phase_t      phase      = PH_KEY;
        logic [31:0] pos        = '0;
        int unsigned field_cnt  = 0;
        logic        key_zero   = 1'b1;
        logic [31:0] span       = '0;
        logic [31:0] rec_start  = '0;
        logic [31:0] skip_left  = '0;
        int unsigned found      = 0;
        logic        done       = 1'b0;
        result_t     due_results[$];
        int unsigned bytes_taken = 0;
        int unsigned checked     = 0;
        int unsigned errors      = 0;

        function void set_length(logic [31:0] v);
            stream_len = v;
        endfunction

        function void add_result(logic kind, int unsigned num, logic [31:0] at,
                                 logic [31:0] plen, logic [REASON_W-1:0] why);
            result_t r;
            r.kind    = kind;
            r.number  = num[NUM_W-1:0];
            r.start   = at;
            r.payload = plen;
            r.reason  = why;
            r.last    = 1'b0;
            due_results.push_back(r);
        endfunction

        function void finish_walk(logic [31:0] at, logic [REASON_W-1:0] why);
            add_result(KIND_FINISH, found, at, 32'd0, why);
            done = 1'b1;
        endfunction

        // a new record slot must leave room for key and span, and the table a free entry
        function bit slot_ends(logic [63:0] s);
            rec_start = s[31:0];
            if (s + KEY_BYTES + SPAN_BYTES > {32'd0, stream_len})
            begin
                finish_walk(s[31:0], STOP_END);
                return 1'b1;
            end
            if (found >= MAX_RECORDS)
            begin
                finish_walk(s[31:0], STOP_TABLE_FULL);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // one accepted stream byte
        function void take_byte(logic [7:0] b);
            logic [63:0] next_slot;
            int unsigned mark;
            if (done)
                return;
            mark = due_results.size();
            bytes_taken++;
            if (phase == PH_KEY && field_cnt == 0 && pos == 0 && slot_ends(64'd0))
            begin
                due_results[$].last = 1'b1;
                return;
            end
            case (phase)
                PH_KEY:
                begin
                    if (field_cnt == 0)
                    begin
                        rec_start = pos;
                        key_zero  = 1'b1;
                    end
                    if (b != 8'd0)
                        key_zero = 1'b0;
                    field_cnt++;
                    if (field_cnt >= KEY_BYTES)
                    begin
                        if (key_zero)
                            finish_walk(rec_start, STOP_ZERO_KEY);
                        else
                        begin
                            phase     = PH_SPAN;
                            field_cnt = 0;
                            span      = '0;
                        end
                    end
                end
                PH_SPAN:
                begin
                    span[field_cnt*8 +: 8] = b;
                    field_cnt++;
                    if (field_cnt >= SPAN_BYTES)
                    begin
                        next_slot = {32'd0, rec_start} + KEY_BYTES + {32'd0, span};
                        field_cnt = 0;
                        if (span < SPAN_BYTES)
                            finish_walk(rec_start, STOP_SHORT_SPAN);
                        else if (next_slot > {32'd0, stream_len})
                            finish_walk(rec_start, STOP_OVERRUN);
                        else
                        begin
                            add_result(KIND_RECORD, found, rec_start, span - SPAN_BYTES,
                                       STOP_NONE);
                            found++;
                            skip_left = span - SPAN_BYTES;
                            if (skip_left == 0)
                            begin
                                phase = PH_KEY;
                                void'(slot_ends(next_slot));
                            end
                            else
                                phase = PH_SKIP;
                        end
                    end
                end
                default:
                begin
                    if (skip_left > 0)
                        skip_left--;
                    if (skip_left == 0)
                    begin
                        next_slot = {32'd0, rec_start} + KEY_BYTES + {32'd0, span};
                        phase     = PH_KEY;
                        field_cnt = 0;
                        void'(slot_ends(next_slot));
                    end
                end
            endcase
            pos++;
            if (due_results.size() > mark)
                due_results[$].last = 1'b1;
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                errors++;
                if (errors <= 40)
                    $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        // one accepted result beat against the oldest one due
        function void match_result(result_t got);
            result_t want;
            checked++;
            if (due_results.size() == 0)
            begin
                errors++;
                if (errors <= 40)
                    $display("%0t: result beat expected none, got kind %0d number %0d start %0d",
                             $time, got.kind, got.number, got.start);
                return;
            end
            want = due_results.pop_front();
            check_field("result_kind", 32'(want.kind), 32'(got.kind));
            check_field("record_number", 32'(want.number), 32'(got.number));
            check_field("record_start", want.start, got.start);
            check_field("payload_bytes", want.payload, got.payload);
            check_field("stop_reason", 32'(want.reason), 32'(got.reason));
            check_field("last_result", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] stream_length;
    logic        out_valid;
    logic        out_ready;
    logic        result_kind;
    logic [12:0] record_number;
    logic [31:0] record_start;
    logic [31:0] payload_bytes;
    logic [2:0]  stop_reason;
    logic        last_result;

    deframe_board_t board = new();
    walk_end_t    end_case;
    int           in_gap_pct    = 0;
    int           out_stall_pct = 0;
    int unsigned  sent_bytes    = 0;
    int unsigned  length_writes = 0;

    hash_length_record_deframer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .stream_length (stream_length),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_kind   (result_kind),
        .record_number (record_number),
        .record_start  (record_start),
        .payload_bytes (payload_bytes),
        .stop_reason   (stop_reason),
        .last_result   (last_result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // beat monitors and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                board.set_length(stream_length);
            if (in_valid && in_ready)
                board.take_byte(data_byte);
            if (out_valid && out_ready)
                board.match_result({result_kind, record_number, record_start,
                                    payload_bytes, stop_reason, last_result});
        end
        out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end

    // one stream byte, with a random gap in front of it
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(0, 99) < in_gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < in_gap_pct);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        sent_bytes++;
    endtask

    task automatic write_length(input logic [31:0] v);
        cfg_valid     <= 1'b1;
        stream_length <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        length_writes++;
        @(posedge clk);
    endtask

    // hold the sender until every due beat has come, then let the block go quiet
    task automatic settle_walk();
        in_valid <= 1'b0;
        while (board.due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_key(input key_style_t style);
        logic [7:0] k [KEY_BYTES];
        int         hot;
        hot = $urandom_range(0, KEY_BYTES - 1);
        foreach (k[i])
        begin
            case (style)
                KEY_ZERO:    k[i] = 8'h00;
                KEY_ONES:    k[i] = 8'hFF;
                KEY_ONE_HOT: k[i] = (i == hot) ? 8'($urandom_range(1, 255)) : 8'h00;
                default:     k[i] = 8'($urandom_range(0, 255));
            endcase
        end
        if (style == KEY_RANDOM)
            k[hot] = k[hot] | 8'h01;
        foreach (k[i])
            send_byte(k[i]);
    endtask

    // span goes out little-endian
    task automatic send_span(input logic [31:0] v);
        for (int i = 0; i < SPAN_BYTES; i++)
            send_byte(v[8*i +: 8]);
    endtask

    task automatic send_record(input key_style_t style, input logic [31:0] pay);
        send_key(style);
        send_span(pay + SPAN_BYTES);
        repeat (pay) send_byte(8'($urandom_range(0, 255)));
    endtask

    // mostly short payloads, some empty, a few long
    function automatic logic [31:0] pick_payload();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return 32'd0;
        if (r < 92)
            return 32'($urandom_range(1, 16));
        return 32'($urandom_range(17, 300));
    endfunction

    task automatic random_records(input int unsigned n);
        int unsigned goal;
        int unsigned r;
        goal = sent_bytes + n;
        while (sent_bytes < goal)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                send_record(KEY_ONE_HOT, pick_payload());
            else if (r < 15)
                send_record(KEY_ONES, pick_payload());
            else
                send_record(KEY_RANDOM, pick_payload());
        end
    endtask

    // bring the walk to the chosen end, then trail a few bytes
    task automatic close_walk(input walk_end_t how);
        logic [31:0] at;
        logic [31:0] pay;
        logic [31:0] cut;
        at = board.pos;
        case (how)
            END_OF_DATA:
            begin
                // the record fits, the slot after it has no room left
                pay = pick_payload();
                cut = at + KEY_BYTES + SPAN_BYTES + pay;
                write_length(cut + $urandom_range(0, KEY_BYTES + SPAN_BYTES - 1));
                send_record(KEY_RANDOM, pay);
            end
            END_ZERO_KEY:
                send_key(KEY_ZERO);
            END_SHORT_SPAN:
            begin
                send_key(KEY_RANDOM);
                send_span($urandom_range(0, SPAN_BYTES - 1));
            end
            END_OVERRUN:
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        send_key(KEY_ONES);
                        send_span(32'hFFFF_FFFF);
                    end
                    1:
                    begin
                        // length cut to nothing under a walk in progress
                        write_length(32'd0);
                        send_record(KEY_RANDOM, 32'd0);
                    end
                    default:
                    begin
                        // one byte past the end, sum above 32 bits
                        send_key(KEY_RANDOM);
                        send_span(32'hFFFF_FFFF - at - KEY_BYTES + 1);
                    end
                endcase
            end
            END_OPEN_RECORD:
            begin
                // record reaching exactly to the end of a full-size stream
                send_key(KEY_RANDOM);
                send_span(32'hFFFF_FFFF - at - KEY_BYTES);
            end
            default: ;
        endcase
        repeat (40) send_byte(8'($urandom_range(0, 255)));
    endtask

    // stimulus
    initial
    begin
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        data_byte     <= 8'd0;
        cfg_valid     <= 1'b0;
        stream_length <= 32'd0;
        out_ready     <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        end_case = walk_end_t'($urandom_range(0, 5));
        write_length(32'd0);
        in_gap_pct    = 12;
        out_stall_pct = 79;

        if (end_case == END_FIRST_SLOT)
        begin
            // no room for even one record: the first byte ends the walk
            case ($urandom_range(0, 2))
                0:       write_length(32'd0);
                1:       write_length(KEY_BYTES + SPAN_BYTES - 1);
                default: write_length($urandom_range(1, KEY_BYTES + SPAN_BYTES - 2));
            endcase
            send_byte(8'($urandom_range(0, 255)));
            settle_walk();

            // every later byte is ignored
            repeat (620) send_byte(8'($urandom_range(0, 255)));
            in_gap_pct    = 79;
            out_stall_pct = 12;
            repeat (620) send_byte(8'($urandom_range(0, 255)));
            in_gap_pct    = 0;
            out_stall_pct = 0;
            repeat (610) send_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            write_length(32'hFFFF_FFFF);

            // directed records
            send_record(KEY_ONES, 32'd0);
            send_record(KEY_ONE_HOT, 32'd1);
            send_record(KEY_ONE_HOT, 32'd0);
            send_record(KEY_RANDOM, 32'd256);
            send_record(KEY_RANDOM, 32'd3);

            random_records(250);
            settle_walk();

            write_length($urandom_range(32'h0010_0000, 32'hFFFF_FFFE));
            in_gap_pct    = 79;
            out_stall_pct = 12;
            random_records(540);
            settle_walk();

            write_length(32'hFFFF_FFFF);
            in_gap_pct    = 0;
            out_stall_pct = 0;
            random_records(440);
            settle_walk();

            close_walk(end_case);
        end

        // drain what is still due
        in_valid <= 1'b0;
        for (int i = 0; i < 5000 && board.due_results.size() != 0; i++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (board.due_results.size() != 0)
        begin
            board.errors++;
            $display("%0t: %0d result beats expected, none arrived",
                     $time, board.due_results.size());
        end

        $display("walk of %0d stream bytes gave %0d result beats and %0d records",
                 board.bytes_taken, board.checked, board.found);
        $display("%0d length writes, walk closed by %s", length_writes, end_case.name());
        if (board.errors == 0)
            $display("hash_length_record_deframer: match");
        else
            $display("hash_length_record_deframer: mismatch");
        $finish;
    end

    // run limit
    initial
    begin
        #6ms;
        $display("hash_length_record_deframer: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/hlrd_pkg.sv
sv/hlrd_step.sv
sv/hlrd_result_fifo.sv
sv/hash_length_record_deframer.sv
bench/tb_top.sv
